@@ hw/rtl/lpps_pkg.sv @@
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared types and codes for the long-press power switch controller.
// ----------------------------------------------------------------------------
package lpps_pkg;

  localparam int STEP_TICKS_W  = 16;
  localparam int HOLD_ROUNDS_W = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int PHASE_W       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TICKS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_ROUNDS = 2'd1;

  localparam logic [STEP_TICKS_W-1:0]  STEP_TICKS_RESET  = 16'd100;
  localparam logic [HOLD_ROUNDS_W-1:0] HOLD_ROUNDS_RESET = 8'd10;

  localparam logic [PHASE_W-1:0] PHASE_START = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_HOLD1 = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_BLINK = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_ABORT = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_WATCH = 3'd4;
  localparam logic [PHASE_W-1:0] PHASE_HOLD2 = 3'd5;
  localparam logic [PHASE_W-1:0] PHASE_OFF   = 3'd6;

  typedef enum logic [6:0] {
    ST_START = 7'b0000001,
    ST_HOLD1 = 7'b0000010,
    ST_BLINK = 7'b0000100,
    ST_ABORT = 7'b0001000,
    ST_WATCH = 7'b0010000,
    ST_HOLD2 = 7'b0100000,
    ST_OFF   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic               power_enable;
    logic               source_usb;
    logic               ready_pulse;
    logic               shutdown_pulse;
    logic [PHASE_W-1:0] phase;
  } status_t;

  function automatic logic [PHASE_W-1:0] phase_code(input state_t st);
    logic [PHASE_W-1:0] code;
    unique case (st)
      ST_START: code = PHASE_START;
      ST_HOLD1: code = PHASE_HOLD1;
      ST_BLINK: code = PHASE_BLINK;
      ST_ABORT: code = PHASE_ABORT;
      ST_WATCH: code = PHASE_WATCH;
      ST_HOLD2: code = PHASE_HOLD2;
      default:  code = PHASE_OFF;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/lpps_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpps_ctrl
// Configuration registers, phase machine, tick and step counters. Produces
// the result for the tick being retired and updates state on advance.
// ----------------------------------------------------------------------------
module lpps_ctrl
  import lpps_pkg::*;
#(
  parameter int NUM_LEDS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   advance,
  input  logic                   level,
  output logic [NUM_LEDS-1:0]    res_leds,
  output status_t                res_status
);

  localparam int STEP_W = $clog2((1 << HOLD_ROUNDS_W) * NUM_LEDS);
  localparam int POS_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(NUM_LEDS - 1);
  localparam logic [STEP_W-1:0] LEDS_N   = STEP_W'(NUM_LEDS);

  logic [STEP_TICKS_W-1:0]  step_ticks;
  logic [HOLD_ROUNDS_W-1:0] hold_rounds;

  state_t                  state, state_next;
  logic                    pressed_seen;
  logic [STEP_TICKS_W-1:0] tick_count, tick_count_next;
  logic [STEP_W-1:0]       step_count, step_count_next;
  logic [POS_W-1:0]        led_pos, led_pos_next;
  logic                    blink_on, blink_on_next;
  logic                    source_is_usb, source_is_usb_next;
  logic                    enable_latch, enable_latch_next;

  logic                     pressed, edge_seen;
  logic [STEP_TICKS_W-1:0]  tick_lim, tick_inc;
  logic                     tick_hit;
  logic [HOLD_ROUNDS_W-1:0] rounds;
  logic [STEP_W-1:0]        steps_total, step_inc;
  logic                     chase_hit;
  logic [POS_W-1:0]         pos_inc;
  logic                     ready_p, shut_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks  <= STEP_TICKS_RESET;
      hold_rounds <= HOLD_ROUNDS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_TICKS:  step_ticks  <= cfg_data[STEP_TICKS_W-1:0];
        REG_HOLD_ROUNDS: hold_rounds <= cfg_data[HOLD_ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pressed     = ~level;
  assign edge_seen   = pressed != pressed_seen;
  assign tick_lim    = (step_ticks == '0) ? STEP_TICKS_W'(1) : step_ticks;
  assign tick_inc    = tick_count + STEP_TICKS_W'(1);
  assign tick_hit    = tick_inc >= tick_lim;
  assign rounds      = (hold_rounds == '0) ? HOLD_ROUNDS_W'(1) : hold_rounds;
  assign steps_total = STEP_W'(rounds) * LEDS_N;
  assign step_inc    = step_count + STEP_W'(1);
  assign chase_hit   = step_inc >= steps_total;
  assign pos_inc     = (led_pos == POS_LAST) ? '0 : led_pos + POS_W'(1);

  always_comb begin
    state_next         = state;
    tick_count_next    = tick_count;
    step_count_next    = step_count;
    led_pos_next       = led_pos;
    blink_on_next      = blink_on;
    source_is_usb_next = source_is_usb;
    enable_latch_next  = enable_latch;
    ready_p            = 1'b0;
    shut_p             = 1'b0;
    unique case (state)
      ST_START: begin
        if (!pressed) begin
          source_is_usb_next = 1'b1;
          ready_p            = 1'b1;
          state_next         = ST_WATCH;
        end else begin
          source_is_usb_next = 1'b0;
          tick_count_next    = '0;
          step_count_next    = '0;
          led_pos_next       = '0;
          state_next         = ST_HOLD1;
        end
      end
      ST_HOLD1, ST_HOLD2: begin
        if (edge_seen) begin
          state_next = (state == ST_HOLD1) ? ST_ABORT : ST_WATCH;
        end else begin
          tick_count_next = tick_hit ? '0 : tick_inc;
          if (tick_hit) begin
            step_count_next = step_inc;
            led_pos_next    = pos_inc;
            if (chase_hit) begin
              if (state == ST_HOLD1) begin
                enable_latch_next = 1'b1;
                blink_on_next     = 1'b1;
                tick_count_next   = '0;
                state_next        = ST_BLINK;
              end else begin
                enable_latch_next = 1'b0;
                shut_p            = 1'b1;
                state_next        = ST_OFF;
              end
            end
          end
        end
      end
      ST_BLINK: begin
        if (edge_seen) begin
          ready_p    = 1'b1;
          state_next = ST_WATCH;
        end else begin
          tick_count_next = tick_hit ? '0 : tick_inc;
          if (tick_hit) begin
            blink_on_next = ~blink_on;
          end
        end
      end
      ST_WATCH: begin
        if (edge_seen && pressed) begin
          tick_count_next = '0;
          step_count_next = '0;
          led_pos_next    = '0;
          state_next      = ST_HOLD2;
        end
      end
      ST_ABORT: ;
      default: state_next = ST_OFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_START;
      pressed_seen  <= 1'b1;
      tick_count    <= '0;
      step_count    <= '0;
      led_pos       <= '0;
      blink_on      <= 1'b1;
      source_is_usb <= 1'b0;
      enable_latch  <= 1'b0;
    end else if (advance) begin
      state         <= state_next;
      pressed_seen  <= pressed;
      tick_count    <= tick_count_next;
      step_count    <= step_count_next;
      led_pos       <= led_pos_next;
      blink_on      <= blink_on_next;
      source_is_usb <= source_is_usb_next;
      enable_latch  <= enable_latch_next;
    end
  end

  always_comb begin
    res_leds = '0;
    if (state_next == ST_HOLD1 || state_next == ST_HOLD2) begin
      for (int k = 0; k < NUM_LEDS; k++) begin
        res_leds[k] = led_pos_next == POS_W'(k);
      end
    end else if (state_next == ST_BLINK) begin
      res_leds = blink_on_next ? '1 : '0;
    end
  end

  assign res_status.power_enable   = enable_latch_next;
  assign res_status.source_usb     = source_is_usb_next;
  assign res_status.ready_pulse    = ready_p;
  assign res_status.shutdown_pulse = shut_p;
  assign res_status.phase          = phase_code(state_next);

endmodule

@@ hw/rtl/long_press_power_switch_controller.sv @@
// ----------------------------------------------------------------------------
// long_press_power_switch_controller
// Long-press power switch controller: input register, phase logic, result
// register. One tick sample in, one status beat out.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_ready       button_level
//   out      source     out_valid / out_ready     leds, power_enable,
//                                                 source_usb, ready_pulse,
//                                                 shutdown_pulse, phase
//   cfg      sink       cfg_write                 cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready is high; a tick sample moves
// from the input register into the result register once the result register
// is empty or being taken, and its status beat is then offered from there.
// The phase logic and counters update when a beat moves from the input
// register into the result register.
// Synchronous reset empties both stages and resets the phase and configuration.
// A stalled result holds; the input register still takes a beat while the
// result waits, then input stalls.
// ----------------------------------------------------------------------------
module long_press_power_switch_controller
  import lpps_pkg::*;
#(
  parameter int NUM_LEDS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   button_level,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NUM_LEDS-1:0]    leds,
  output logic                   power_enable,
  output logic                   source_usb,
  output logic                   ready_pulse,
  output logic                   shutdown_pulse,
  output logic [PHASE_W-1:0]     phase
);

  logic    hold_valid;
  logic    hold_level;
  logic    advance;
  logic [NUM_LEDS-1:0] res_leds;
  status_t res_status;
  status_t status;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_level <= button_level;
    end
  end

  lpps_ctrl #(
    .NUM_LEDS (NUM_LEDS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .level      (hold_level),
    .res_leds   (res_leds),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      leds   <= res_leds;
      status <= res_status;
    end
  end

  assign power_enable   = status.power_enable;
  assign source_usb     = status.source_usb;
  assign ready_pulse    = status.ready_pulse;
  assign shutdown_pulse = status.shutdown_pulse;
  assign phase          = status.phase;

  a_shutdown_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && shutdown_pulse |-> phase == PHASE_OFF && !power_enable)
    else $error("shutdown beat not in off phase with enable dropped");

  a_ready_watch: assert property (@(posedge clk) disable iff (rst)
    out_valid && ready_pulse |-> phase == PHASE_WATCH)
    else $error("ready beat not in watch phase");

  a_blink_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PHASE_BLINK |-> power_enable)
    else $error("blink phase without power enable");

  a_dark_phases: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == PHASE_WATCH || phase == PHASE_ABORT || phase == PHASE_OFF)
    |-> leds == '0)
    else $error("leds lit outside hold or blink");

  a_hold_drains: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat lost before result register");

endmodule

@@ dv/long_press_power_switch_controller_checker.sv @@
// ----------------------------------------------------------------------------
// long_press_power_switch_controller_checker
// Watches the tick and status channels of the power switch controller. Each
// accepted tick is run through a cycle-free model of the phase logic, and the
// status beat it predicts is queued. Each accepted status beat is compared
// field by field with the oldest queued prediction. Register writes update
// the model's copy of the configuration.
// ----------------------------------------------------------------------------
module long_press_power_switch_controller_checker
  import lpps_pkg::*;
#(
  parameter int NUM_LEDS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   button_level,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [NUM_LEDS-1:0]    leds,
  input  logic                   power_enable,
  input  logic                   source_usb,
  input  logic                   ready_pulse,
  input  logic                   shutdown_pulse,
  input  logic [PHASE_W-1:0]     phase,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_LEDS-1:0] leds;
    status_t             status;
  } tick_status_t;

  logic [STEP_TICKS_W-1:0]  step_ticks_cfg;
  logic [HOLD_ROUNDS_W-1:0] hold_rounds_cfg;

  logic [PHASE_W-1:0] cur_phase;
  logic               held;
  logic [15:0]        tick_cnt;
  logic [9:0]         step_cnt;
  logic               blink_lit;
  logic               usb_seen;
  logic               enabled;

  tick_status_t status_q[$];
  int           beats_seen;

  function automatic bit step_elapsed();
    logic [15:0] lim;
    lim = (step_ticks_cfg == '0) ? 16'd1 : step_ticks_cfg;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit chase_elapsed();
    int target;
    target = ((hold_rounds_cfg == '0) ? 1 : int'(hold_rounds_cfg)) * NUM_LEDS;
    if (!step_elapsed())
      return 1'b0;
    step_cnt = step_cnt + 10'd1;
    return int'(step_cnt) >= target;
  endfunction

  function automatic tick_status_t next_status(input logic level);
    tick_status_t r;
    logic         pressed;
    logic         toggled;
    r       = '0;
    pressed = ~level;
    toggled = (pressed != held);
    held    = pressed;
    case (cur_phase)
      PHASE_START: begin
        if (!pressed) begin
          usb_seen             = 1'b1;
          r.status.ready_pulse = 1'b1;
          cur_phase            = PHASE_WATCH;
        end else begin
          usb_seen  = 1'b0;
          tick_cnt  = '0;
          step_cnt  = '0;
          cur_phase = PHASE_HOLD1;
        end
      end
      PHASE_HOLD1: begin
        if (toggled) begin
          cur_phase = PHASE_ABORT;
        end else if (chase_elapsed()) begin
          enabled   = 1'b1;
          blink_lit = 1'b1;
          tick_cnt  = '0;
          cur_phase = PHASE_BLINK;
        end
      end
      PHASE_BLINK: begin
        if (toggled) begin
          r.status.ready_pulse = 1'b1;
          cur_phase            = PHASE_WATCH;
        end else if (step_elapsed()) begin
          blink_lit = ~blink_lit;
        end
      end
      PHASE_WATCH: begin
        if (toggled && pressed) begin
          tick_cnt  = '0;
          step_cnt  = '0;
          cur_phase = PHASE_HOLD2;
        end
      end
      PHASE_HOLD2: begin
        if (toggled) begin
          cur_phase = PHASE_WATCH;
        end else if (chase_elapsed()) begin
          enabled                 = 1'b0;
          r.status.shutdown_pulse = 1'b1;
          cur_phase               = PHASE_OFF;
        end
      end
      PHASE_ABORT: ;
      default: cur_phase = PHASE_OFF;
    endcase
    if (cur_phase == PHASE_HOLD1 || cur_phase == PHASE_HOLD2)
      r.leds[step_cnt % NUM_LEDS] = 1'b1;
    else if (cur_phase == PHASE_BLINK && blink_lit)
      r.leds = '1;
    r.status.power_enable = enabled;
    r.status.source_usb   = usb_seen;
    r.status.phase        = cur_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_status_t want;
    tick_status_t got;
    if (rst) begin
      step_ticks_cfg  = STEP_TICKS_RESET;
      hold_rounds_cfg = HOLD_ROUNDS_RESET;
      cur_phase       = PHASE_START;
      held            = 1'b1;
      tick_cnt        = '0;
      step_cnt        = '0;
      blink_lit       = 1'b1;
      usb_seen        = 1'b0;
      enabled         = 1'b0;
      fail_count      = 0;
      beats_seen      = 0;
      status_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STEP_TICKS:  step_ticks_cfg  = cfg_data[STEP_TICKS_W-1:0];
          REG_HOLD_ROUNDS: hold_rounds_cfg = cfg_data[HOLD_ROUNDS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {leds, power_enable, source_usb, ready_pulse, shutdown_pulse, phase};
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("status beat %0d arrived with no tick pending: leds %h phase %0d",
                     beats_seen, got.leds, got.status.phase);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("status beat %0d exp/got: leds %h/%h en %b/%b usb %b/%b ",
                     beats_seen, want.leds, got.leds,
                     want.status.power_enable, got.status.power_enable,
                     want.status.source_usb, got.status.source_usb);
              $display("rdy %b/%b shut %b/%b phase %0d/%0d",
                       want.status.ready_pulse, got.status.ready_pulse,
                       want.status.shutdown_pulse, got.status.shutdown_pulse,
                       want.status.phase, got.status.phase);
            end
          end
        end
        beats_seen++;
      end
      if (in_valid && in_ready)
        status_q.push_back(next_status(button_level));
    end
    pending = status_q.size();
  end

endmodule

@@ dv/long_press_power_switch_controller_tb.sv @@
// ----------------------------------------------------------------------------
// long_press_power_switch_controller_tb
// Drives tick samples into the power switch controller in random bursts while
// the status side stalls on its own pattern. The run takes one power-up path
// per seed (battery hold, USB, or an aborted hold). After a battery hold or USB
// start it spends most ticks in the watch phase on press episodes cancelled at
// random points under several register settings, and ends in a long-press shutdown.
// ----------------------------------------------------------------------------
module long_press_power_switch_controller_tb;
  import lpps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEDS       = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   button_level;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [NUM_LEDS-1:0]    leds;
  logic                   power_enable;
  logic                   source_usb;
  logic                   ready_pulse;
  logic                   shutdown_pulse;
  logic [PHASE_W-1:0]     phase;

  int fail_count;
  int pending;
  int quiet_cycles;
  int burst_left;
  int items_sent;
  int chase_len;
  int low_run;

  logic [7:0] stall_pat = 8'hFF;
  logic [2:0] stall_pos = '0;
  int         stall_left;

  long_press_power_switch_controller #(
    .NUM_LEDS(NUM_LEDS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_level  (button_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .leds          (leds),
    .power_enable  (power_enable),
    .source_usb    (source_usb),
    .ready_pulse   (ready_pulse),
    .shutdown_pulse(shutdown_pulse),
    .phase         (phase)
  );

  long_press_power_switch_controller_checker #(
    .NUM_LEDS(NUM_LEDS)
  ) status_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_level  (button_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .leds          (leds),
    .power_enable  (power_enable),
    .source_usb    (source_usb),
    .ready_pulse   (ready_pulse),
    .shutdown_pulse(shutdown_pulse),
    .phase         (phase),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0:       stall_pat <= 8'hFF;
        1:       stall_pat <= 8'h55;
        default: stall_pat <= 8'($urandom) | 8'h01;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_pos <= stall_pos + 3'd1;
    out_ready <= stall_pat[stall_pos];
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_tick(input logic level);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5))
        @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
    end
    in_valid     = 1'b1;
    button_level = level;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  // hold the press short of a full chase, so the block stays alive
  task automatic watch_tick(input logic level);
    if (!level && low_run >= chase_len)
      level = 1'b1;
    push_tick(level);
    low_run = level ? 0 : low_run + 1;
  endtask

  task automatic retune(input logic [CFG_DATA_W-1:0] step_val,
                        input logic [CFG_DATA_W-1:0] rounds_val);
    int eff_step;
    int eff_rounds;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = REG_STEP_TICKS;
    cfg_data  = step_val;
    @(negedge clk);
    cfg_index = REG_HOLD_ROUNDS;
    cfg_data  = rounds_val;
    @(negedge clk);
    cfg_write  = 1'b0;
    eff_step   = (step_val == '0) ? 1 : int'(step_val);
    eff_rounds = (rounds_val[7:0] == '0) ? 1 : int'(rounds_val[7:0]);
    chase_len  = eff_step * eff_rounds * NUM_LEDS;
  endtask

  initial begin
    int          start_path;
    int          base;
    int          span;
    int          n;
    logic [15:0] step_val;
    logic [15:0] rounds_val;

    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_STEP_TICKS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    button_level = 1'b1;
    burst_left   = 0;
    items_sent   = 0;
    low_run      = 0;
    chase_len    = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    retune(16'd2, 16'h0001);
    start_path = $urandom_range(0, 15);
    if (start_path == 0) begin
      push_tick(1'b0);
      push_tick(1'b0);
      push_tick(1'b1);
      repeat (1650) push_tick(1'($urandom_range(0, 1)));
    end else begin
      if (start_path <= 2) begin
        push_tick(1'b1);
      end else begin
        repeat (14) push_tick(1'b0);
        push_tick(1'b1);
      end
      watch_tick(1'b0);
      watch_tick(1'b0);
      watch_tick(1'b1);
      retune(16'd0, 16'hFF00);
      repeat (4) watch_tick(1'b0);
      watch_tick(1'b1);
      retune(16'hFFFF, 16'hA5FF);
      repeat (2) watch_tick(1'b0);
      watch_tick(1'b1);

      repeat (8) begin
        case ($urandom_range(0, 7))
          0: begin
            step_val   = 16'($urandom);
            rounds_val = 16'($urandom);
          end
          1: begin
            step_val   = 16'd0;
            rounds_val = {8'($urandom), 8'h00};
          end
          2: begin
            step_val   = 16'hFFFF;
            rounds_val = 16'h00FF;
          end
          default: begin
            step_val   = 16'($urandom_range(1, 5));
            rounds_val = {8'($urandom), 8'($urandom_range(1, 3))};
          end
        endcase
        retune(step_val, rounds_val);
        base = items_sent;
        while (items_sent - base < 210) begin
          if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(8, 30)) watch_tick(1'($urandom_range(0, 1)));
          end else begin
            span = (chase_len < 40) ? chase_len : 40;
            if (chase_len <= 64 && $urandom_range(0, 3) == 0)
              n = chase_len;
            else
              n = $urandom_range(1, span);
            repeat (n) watch_tick(1'b0);
            repeat ($urandom_range(1, 4)) watch_tick(1'b1);
          end
        end
      end

      retune(16'd1, 16'h0001);
      repeat (NUM_LEDS + 1) push_tick(1'b0);
      repeat (6) push_tick(1'($urandom_range(0, 1)));
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
